// ===== rtl/qslerp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_pkg
// shared widths, angle constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package qslerp_pkg;

    localparam int FRAC_BITS  = 14;   // q2.14 word format
    localparam int WF         = 30;   // internal fraction bits
    localparam int C_W        = 30;   // |dot| in q.30
    localparam int V_W        = 61;   // 2^60 - c*c
    localparam int SQ_W       = 62;   // square root working width
    localparam int S_W        = 31;   // sine of half angle
    localparam int XY_W       = 34;   // cordic x and y
    localparam int ANG_W      = 36;   // angles in q.30
    localparam int NUM_W      = 52;   // blend numerator
    localparam int Q_W        = 16;   // quotient bits
    localparam int SQRT_STEPS = 31;

    localparam logic signed [ANG_W-1:0] PI_A      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_A = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_A  = 36'sd6746518852;
    localparam logic signed [XY_W-1:0]  GAIN_XY   = 34'sd652032874;

    localparam logic [1:0] PATH_FIRST = 2'd0;
    localparam logic [1:0] PATH_AVG   = 2'd1;
    localparam logic [1:0] PATH_BLEND = 2'd2;

    function automatic logic [30:0] atan_w(input logic [4:0] i);
        logic [30:0] r;
        case (i)
            5'd0:    r = 31'd843314857;
            5'd1:    r = 31'd497837830;
            5'd2:    r = 31'd263043837;
            5'd3:    r = 31'd133525159;
            5'd4:    r = 31'd67021687;
            5'd5:    r = 31'd33543516;
            5'd6:    r = 31'd16775851;
            5'd7:    r = 31'd8388437;
            5'd8:    r = 31'd4194283;
            5'd9:    r = 31'd2097149;
            5'd31:   r = 31'd0;
            default: r = 31'd1 << (5'd30 - i);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/qslerp_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module qslerp_sqrt (
    input  logic                        clk,
    input  logic [qslerp_pkg::V_W-1:0]  v,
    output logic [qslerp_pkg::S_W-1:0]  root
);
    import qslerp_pkg::*;

    logic [SQ_W-1:0] rem_reg  [0:SQRT_STEPS];
    logic [SQ_W-1:0] root_reg [0:SQRT_STEPS];

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= SQ_W'(v);
        root_reg[0] <= '0;
    end

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_step
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] trial;
        assign bitv  = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));
        assign trial = root_reg[j] + bitv;

        always_ff @(posedge clk)
        begin
            if (rem_reg[j] >= trial)
            begin
                rem_reg[j+1]  <= rem_reg[j] - trial;
                root_reg[j+1] <= (root_reg[j] >> 1) + bitv;
            end
            else
            begin
                rem_reg[j+1]  <= rem_reg[j];
                root_reg[j+1] <= root_reg[j] >> 1;
            end
        end
    end

    assign root = root_reg[SQRT_STEPS][S_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/qslerp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_div
// four-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module qslerp_div (
    input  logic                                clk,
    input  logic [3:0][qslerp_pkg::NUM_W-1:0]   mag,
    input  logic [qslerp_pkg::S_W-1:0]          s,
    output logic [3:0][qslerp_pkg::Q_W-1:0]     q
);
    import qslerp_pkg::*;

    typedef struct packed {
        logic [3:0][NUM_W-1:0] rem;
        logic [3:0][Q_W-1:0]   quo;
        logic [S_W-1:0]        s;
    } div_t;

    div_t st_in;
    div_t st_reg [1:Q_W];

    always_comb
    begin
        st_in.rem = mag;
        st_in.quo = '0;
        st_in.s   = s;
    end

    for (genvar j = 0; j < Q_W; j++)
    begin : g_step
        logic [NUM_W-1:0] d;
        div_t             st_cur;
        div_t             st_next;

        if (j == 0)
        begin : g_first
            assign st_cur = st_in;
        end
        else
        begin : g_rest
            assign st_cur = st_reg[j];
        end

        assign d = NUM_W'(st_cur.s) << (Q_W - 1 - j);

        always_comb
        begin
            st_next = st_cur;
            for (int l = 0; l < 4; l++)
            begin
                if (st_cur.rem[l] >= d)
                begin
                    st_next.rem[l] = st_cur.rem[l] - d;
                    st_next.quo[l] = {st_cur.quo[l][Q_W-2:0], 1'b1};
                end
                else
                begin
                    st_next.quo[l] = {st_cur.quo[l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[j+1] <= st_next;
        end
    end

    assign q = st_reg[Q_W].quo;

endmodule
`default_nettype wire

// ===== rtl/quaternion_slerp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_slerp_core
// fixed-point quaternion slerp, fully pipelined
// ----------------------------------------------------------------------------
// one word enters on every cycle that start is high; busy is always low. each
// result comes out with done high for one cycle, in input order. the receiver
// cannot stall, and none is needed: each word passes through the chain of dot
// product (3 stages), square root (32 stages: input register, then one bit
// each), vectoring cordic, angle scaling and reduction (3 stages), rotating
// cordic, blend products (2 stages), divider (16 stages) and output register.
// write epsilon only while no word is in flight.
module quaternion_slerp_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        epsilon_we,
    input  logic [14:0] epsilon_wdata,
    input  logic [15:0] a_x,
    input  logic [15:0] a_y,
    input  logic [15:0] a_z,
    input  logic [15:0] a_w,
    input  logic [15:0] b_x,
    input  logic [15:0] b_y,
    input  logic [15:0] b_z,
    input  logic [15:0] b_w,
    input  logic [15:0] blend,
    output logic        done,
    output logic [15:0] out_x,
    output logic [15:0] out_y,
    output logic [15:0] out_z,
    output logic [15:0] out_w,
    output logic [1:0]  path
);
    import qslerp_pkg::*;

    localparam int N      = CORDIC_STEPS;
    localparam int IX_M   = N + 1;
    localparam int IX_ROT = 2 * N + 3;
    localparam int IX_F1  = 2 * N + 4;
    localparam int IX_DIV = 2 * N + 21;
    localparam int IX_OUT = 2 * N + 22;
    localparam int SD_LEN = 2 * N + 23;
    localparam int LAT    = 2 * N + 58;
    localparam logic signed [16:0] ONE_T = 17'(1 << FRAC_BITS);
    localparam logic signed [33:0] ONE_D = 34'(1 << (2 * FRAC_BITS));

    // front-end word carried alongside the dot product and square root
    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][16:0] bn;
        logic [15:0]      t;
        logic [C_W-1:0]   c;
        logic             unit;
    } pre_t;

    // word carried alongside the cordic, blend and divide stages
    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][16:0] bn;
        logic [15:0]      t;
        logic [S_W-1:0]   s;
        logic [1:0]       path;
        logic [3:0][15:0] early;
    } side_t;

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        logic [15:0] r;
        if (v > 18'sd32767)
            r = 16'h7fff;
        else if (v < -18'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

    logic [14:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= 15'd2;
        else if (epsilon_we)
            eps_reg <= epsilon_wdata;
    end

    assign busy = 1'b0;

    // ---------------- stage 1: component products
    logic [3:0][15:0] ain, bin;
    assign ain = {a_w, a_z, a_y, a_x};
    assign bin = {b_w, b_z, b_y, b_x};

    logic             v1_reg;
    logic [3:0][15:0] a1_reg, b1_reg;
    logic [15:0]      t1_reg;
    logic signed [31:0] p_reg [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        a1_reg <= ain;
        b1_reg <= bin;
        t1_reg <= blend;
        for (int i = 0; i < 4; i++)
            p_reg[i] <= $signed(ain[i]) * $signed(bin[i]);
    end

    // ---------------- stage 2: dot, unit test, fold to positive dot
    logic signed [33:0] dot, adot;
    logic               dneg;
    pre_t               pre2_next, pre2_reg;
    logic               v2_reg;

    always_comb
    begin
        dot  = p_reg[0] + p_reg[1] + p_reg[2] + p_reg[3];
        dneg = dot[33];
        adot = dneg ? -dot : dot;
        pre2_next.a    = a1_reg;
        pre2_next.t    = t1_reg;
        pre2_next.unit = (dot >= ONE_D) || (dot <= -ONE_D);
        pre2_next.c    = C_W'(adot << (WF - 2 * FRAC_BITS));
        for (int i = 0; i < 4; i++)
        begin
            // -32768 negates to +32768 in the 17-bit lane
            if (dneg)
                pre2_next.bn[i] = -{b1_reg[i][15], b1_reg[i]};
            else
                pre2_next.bn[i] = {b1_reg[i][15], b1_reg[i]};
        end
    end

    // ---------------- stage 3: c squared
    pre_t             pre3_reg;
    logic             v3_reg;
    logic [2*C_W-1:0] csq_reg;
    logic [V_W-1:0]   v_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pre2_reg <= pre2_next;
        pre3_reg <= pre2_reg;
        csq_reg  <= pre2_reg.c * pre2_reg.c;
    end

    assign v_in = (V_W'(1) << (2 * WF)) - V_W'(csq_reg);

    // ---------------- square root, side word delayed to match
    logic [S_W-1:0] root;
    pre_t           pre_reg  [0:SQRT_STEPS];
    logic           prev_reg [0:SQRT_STEPS];

    qslerp_sqrt u_sqrt (
        .clk  (clk),
        .v    (v_in),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        pre_reg[0] <= pre3_reg;
        for (int j = 0; j < SQRT_STEPS; j++)
            pre_reg[j+1] <= pre_reg[j];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= SQRT_STEPS; j++)
                prev_reg[j] <= 1'b0;
        end
        else
        begin
            prev_reg[0] <= v3_reg;
            for (int j = 0; j < SQRT_STEPS; j++)
                prev_reg[j+1] <= prev_reg[j];
        end
    end

    // ---------------- path decision and the early results
    side_t sd_next;
    pre_t  pq;
    logic  avg_sel;

    always_comb
    begin
        pq      = pre_reg[SQRT_STEPS];
        avg_sel = (root == '0) || (root < (S_W'(eps_reg) << (WF - FRAC_BITS)));
        sd_next.a  = pq.a;
        sd_next.bn = pq.bn;
        sd_next.t  = pq.t;
        sd_next.s  = root;
        if (pq.unit)
            sd_next.path = PATH_FIRST;
        else if (avg_sel)
            sd_next.path = PATH_AVG;
        else
            sd_next.path = PATH_BLEND;
        for (int i = 0; i < 4; i++)
        begin
            if (pq.unit)
                sd_next.early[i] = pq.a[i];
            else
                sd_next.early[i] = sat16((($signed({pq.a[i][15], pq.a[i][15], pq.a[i]})
                                    + $signed({pq.bn[i][16], pq.bn[i]})) >>> 1));
        end
    end

    side_t sd_reg  [0:SD_LEN-1];
    logic  sdv_reg [0:SD_LEN-1];

    always_ff @(posedge clk)
    begin
        sd_reg[0] <= sd_next;
        for (int j = 0; j < SD_LEN - 1; j++)
            sd_reg[j+1] <= sd_reg[j];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SD_LEN; j++)
                sdv_reg[j] <= 1'b0;
        end
        else
        begin
            sdv_reg[0] <= prev_reg[SQRT_STEPS];
            for (int j = 0; j < SD_LEN - 1; j++)
                sdv_reg[j+1] <= sdv_reg[j];
        end
    end

    // ---------------- vectoring cordic: half angle from (c, s)
    logic signed [XY_W-1:0]  vx_reg [0:N];
    logic signed [XY_W-1:0]  vy_reg [0:N];
    logic signed [ANG_W-1:0] vz_reg [0:N];

    always_ff @(posedge clk)
    begin
        vx_reg[0] <= XY_W'(pq.c);
        vy_reg[0] <= XY_W'(root);
        vz_reg[0] <= '0;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_vec
        logic signed [XY_W-1:0]  dx, dy;
        logic signed [ANG_W-1:0] at;
        assign dx = vy_reg[k] >>> k;
        assign dy = vx_reg[k] >>> k;
        assign at = ANG_W'(atan_w(5'(k)));

        always_ff @(posedge clk)
        begin
            if (vy_reg[k] > 0)
            begin
                vx_reg[k+1] <= vx_reg[k] + dx;
                vy_reg[k+1] <= vy_reg[k] - dy;
                vz_reg[k+1] <= vz_reg[k] + at;
            end
            else
            begin
                vx_reg[k+1] <= vx_reg[k] - dx;
                vy_reg[k+1] <= vy_reg[k] + dy;
                vz_reg[k+1] <= vz_reg[k] - at;
            end
        end
    end

    // ---------------- scale the half angle by (1 - t) and t
    logic signed [16:0]      ka, kb;
    logic signed [32:0]      h;
    logic signed [49:0]      ma_reg, mb_reg;
    logic signed [ANG_W-1:0] fa, fb, wa_next, wb_next, wa_reg, wb_reg;
    logic signed [ANG_W-1:0] ra_next, rb_next;

    function automatic logic signed [ANG_W-1:0] wrap(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        if (v >= PI_A)
            r = v - TWO_PI_A;
        else if (v < -PI_A)
            r = v + TWO_PI_A;
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [ANG_W-1:0] mirror(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > HALF_PI_A)
            r = PI_A - v;
        else if (v < -HALF_PI_A)
            r = -PI_A - v;
        else
            r = v;
        return r;
    endfunction

    assign kb = $signed({sd_reg[N].t[15], sd_reg[N].t});
    assign ka = ONE_T - kb;
    assign h  = vz_reg[N][32:0];

    always_ff @(posedge clk)
    begin
        ma_reg <= ka * h;
        mb_reg <= kb * h;
    end

    // floor shift back to q.30, then one wrap by 2*pi
    assign fa      = ma_reg[49:FRAC_BITS];
    assign fb      = mb_reg[49:FRAC_BITS];
    assign wa_next = wrap(fa);
    assign wb_next = wrap(fb);

    always_ff @(posedge clk)
    begin
        wa_reg <= wa_next;
        wb_reg <= wb_next;
    end

    assign ra_next = mirror(wa_reg);
    assign rb_next = mirror(wb_reg);

    // ---------------- rotating cordic, two lanes: sin((1-t)h) and sin(th)
    logic signed [XY_W-1:0]  rx_reg [0:1][0:N];
    logic signed [XY_W-1:0]  ry_reg [0:1][0:N];
    logic signed [ANG_W-1:0] rz_reg [0:1][0:N];

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            rx_reg[l][0] <= GAIN_XY;
            ry_reg[l][0] <= '0;
        end
        rz_reg[0][0] <= ra_next;
        rz_reg[1][0] <= rb_next;
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        for (genvar k = 0; k < N; k++)
        begin : g_rot
            logic signed [XY_W-1:0]  dx, dy;
            logic signed [ANG_W-1:0] at;
            assign dx = ry_reg[l][k] >>> k;
            assign dy = rx_reg[l][k] >>> k;
            assign at = ANG_W'(atan_w(5'(k)));

            always_ff @(posedge clk)
            begin
                if (rz_reg[l][k] >= 0)
                begin
                    rx_reg[l][k+1] <= rx_reg[l][k] - dx;
                    ry_reg[l][k+1] <= ry_reg[l][k] + dy;
                    rz_reg[l][k+1] <= rz_reg[l][k] - at;
                end
                else
                begin
                    rx_reg[l][k+1] <= rx_reg[l][k] + dx;
                    ry_reg[l][k+1] <= ry_reg[l][k] - dy;
                    rz_reg[l][k+1] <= rz_reg[l][k] + at;
                end
            end
        end
    end

    // ---------------- blend products, then sign and magnitude
    logic signed [49:0]    pa_reg [0:3];
    logic signed [50:0]    pb_reg [0:3];
    logic [3:0][NUM_W-1:0] mag_reg;
    logic [3:0]            neg_reg, ovf_reg, neg_d_reg [0:Q_W-1], ovf_d_reg [0:Q_W-1];
    logic [S_W-1:0]        s_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            pa_reg[i] <= $signed(sd_reg[IX_ROT].a[i]) * ry_reg[0][N];
            pb_reg[i] <= $signed(sd_reg[IX_ROT].bn[i]) * ry_reg[1][N];
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [NUM_W-1:0] sum;
        logic [NUM_W-1:0]        m;
        s_reg <= sd_reg[IX_F1].s;
        for (int i = 0; i < 4; i++)
        begin
            sum = pa_reg[i] + pb_reg[i];
            m   = sum[NUM_W-1] ? NUM_W'(-sum) : NUM_W'(sum);
            mag_reg[i] <= m;
            neg_reg[i] <= sum[NUM_W-1];
            // quotient of 2^16 or more saturates either way
            ovf_reg[i] <= m >= (NUM_W'(sd_reg[IX_F1].s) << Q_W);
        end
    end

    // ---------------- divide by s, sign and overflow flags ride alongside
    logic [3:0][Q_W-1:0] quo;

    qslerp_div u_div (
        .clk (clk),
        .mag (mag_reg),
        .s   (s_reg),
        .q   (quo)
    );

    always_ff @(posedge clk)
    begin
        neg_d_reg[0] <= neg_reg;
        ovf_d_reg[0] <= ovf_reg;
        for (int j = 0; j < Q_W - 1; j++)
        begin
            neg_d_reg[j+1] <= neg_d_reg[j];
            ovf_d_reg[j+1] <= ovf_d_reg[j];
        end
    end

    // ---------------- output register
    logic [3:0][15:0] res_next, res_reg;
    logic [1:0]       path_reg;
    logic [3:0]       nq, oq;

    assign nq = neg_d_reg[Q_W-1];
    assign oq = ovf_d_reg[Q_W-1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            case (sd_reg[IX_DIV].path)
                PATH_BLEND:
                begin
                    if (nq[i])
                        res_next[i] = (oq[i] || quo[i] > 16'd32768) ? 16'h8000
                                                                   : 16'(-{1'b0, quo[i]});
                    else
                        res_next[i] = (oq[i] || quo[i][15]) ? 16'h7fff : quo[i];
                end
                default:
                    res_next[i] = sd_reg[IX_DIV].early[i];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        path_reg <= sd_reg[IX_DIV].path;
    end

    assign done  = sdv_reg[IX_OUT];
    assign out_x = res_reg[0];
    assign out_y = res_reg[1];
    assign out_z = res_reg[2];
    assign out_w = res_reg[3];
    assign path  = path_reg;

    // ---------------- checks
    // fixed latency from start to done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("result strobe missing at fixed latency");

    // only the three path codes reach the port
    a_path: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (path == PATH_FIRST || path == PATH_AVG || path == PATH_BLEND))
        else $error("bad path code");

    // the blend never divides by zero
    a_div0: assert property (@(posedge clk) disable iff (!rst_n)
        (sdv_reg[0] && sd_reg[0].path == PATH_BLEND) |-> sd_reg[0].s != '0)
        else $error("blend path with zero sine");

    // the multiply stage word is the one that left the vectoring cordic
    a_track: assert property (@(posedge clk) disable iff (!rst_n)
        sdv_reg[IX_M] |-> $past(sdv_reg[N]))
        else $error("valid lost between pipeline sections");

endmodule
`default_nettype wire
